// ===== design/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion unit.
package rmq_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 20;

	typedef enum logic [1:0] {
		CASE_TRACE = 2'd0,
		CASE_X     = 2'd1,
		CASE_Y     = 2'd2,
		CASE_Z     = 2'd3
	} case_t;

	typedef struct packed {
		logic  valid;
		case_t sel;
		logic  degen;
	} ctl_t;

endpackage

// ===== design/rmq_ifs.sv =====
// Valid/ready channel interfaces for matrix beats and quaternion beats.
interface rmq_mat_if #(parameter int DW = 20);
	logic valid;
	logic ready;
	logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_quat_if #(parameter int DW = 20);
	logic valid;
	logic ready;
	logic signed [DW-1:0] quat_w, quat_x, quat_y, quat_z;
	logic [1:0] case_taken;
	logic degenerate;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, case_taken, degenerate,
		input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, case_taken, degenerate,
		output ready);
endinterface

// ===== design/rmq_front.sv =====
// Branch select, radicand and numerator stage.
module rmq_front import rmq_pkg::*; #(
	parameter int DW   = DATA_WIDTH_DEF,
	parameter int FRAC = FRAC_BITS_DEF,
	parameter int RW   = 23,
	parameter int MW   = 21
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld,
	input  logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output ctl_t ctl_s1,
	output logic [RW-2:0] rad_s1,
	output logic [MW-1:0] mag_s1 [3],
	output logic [2:0] neg_s1
);
	logic signed [RW-1:0] a00, a11, a22, tr, rad, one;
	logic signed [MW-1:0] n [3];
	case_t sel;

	assign a00 = RW'(m00);
	assign a11 = RW'(m11);
	assign a22 = RW'(m22);
	assign one = RW'(1) <<< FRAC;
	assign tr  = a00 + a11 + a22;

	always_comb begin
		if (tr > 0) begin
			sel  = CASE_TRACE;
			rad  = tr + one;
			n[0] = MW'(m21) - MW'(m12);
			n[1] = MW'(m02) - MW'(m20);
			n[2] = MW'(m10) - MW'(m01);
		end else if (a00 > a11 && a00 > a22) begin
			sel  = CASE_X;
			rad  = one + a00 - a11 - a22;
			n[0] = MW'(m21) - MW'(m12);
			n[1] = MW'(m01) + MW'(m10);
			n[2] = MW'(m02) + MW'(m20);
		end else if (a11 > a22) begin
			sel  = CASE_Y;
			rad  = one + a11 - a00 - a22;
			n[0] = MW'(m02) - MW'(m20);
			n[1] = MW'(m01) + MW'(m10);
			n[2] = MW'(m12) + MW'(m21);
		end else begin
			sel  = CASE_Z;
			rad  = one + a22 - a00 - a11;
			n[0] = MW'(m10) - MW'(m01);
			n[1] = MW'(m02) + MW'(m20);
			n[2] = MW'(m12) + MW'(m21);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, sel: CASE_TRACE, degen: 1'b0};
		end else if (en) begin
			ctl_s1 <= '{valid: vld, sel: sel, degen: (rad <= 0)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= (rad < 0) ? '0 : rad[RW-2:0];
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= n[k][MW-1];
				mag_s1[k] <= n[k][MW-1] ? MW'(-n[k]) : MW'(n[k]);
			end
		end
	end
endmodule

// ===== design/rmq_sqrt.sv =====
// Pipelined restoring square root, one root bit per stage.
module rmq_sqrt import rmq_pkg::*; #(
	parameter int XW  = 38,
	parameter int SBW = 66,
	localparam int SW = (XW + 1) / 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ctl_t ctl_i,
	input  logic [XW-1:0] x_i,
	input  logic [SBW-1:0] sb_i,
	output ctl_t ctl_o,
	output logic [SW-1:0] root_o,
	output logic [SBW-1:0] sb_o
);
	localparam int PW  = 2 * SW;
	localparam int RMW = SW + 3;

	ctl_t ctl_s [SW];
	logic [PW-1:0] x_s [SW];
	logic [RMW-1:0] rem_s [SW];
	logic [SW-1:0] root_s [SW];
	logic [SBW-1:0] sb_s [SW];

	for (genvar g = 0; g < SW; g++) begin : g_stage
		ctl_t ctl_in;
		logic [PW-1:0] x_in;
		logic [RMW-1:0] rem_in, rem_sh, trial;
		logic [SW-1:0] root_in;
		logic [SBW-1:0] sb_in;
		logic ge;

		if (g == 0) begin : g_first
			assign ctl_in  = ctl_i;
			assign x_in    = PW'(x_i);
			assign rem_in  = '0;
			assign root_in = '0;
			assign sb_in   = sb_i;
		end else begin : g_next
			assign ctl_in  = ctl_s[g-1];
			assign x_in    = x_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign sb_in   = sb_s[g-1];
		end

		assign rem_sh = {rem_in[RMW-3:0], x_in[PW-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '{valid: 1'b0, sel: CASE_TRACE, degen: 1'b0};
			end else if (en) begin
				ctl_s[g] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g]    <= {x_in[PW-3:0], 2'b00};
				rem_s[g]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[g] <= {root_in[SW-2:0], ge};
				sb_s[g]   <= sb_in;
			end
		end
	end

	assign ctl_o  = ctl_s[SW-1];
	assign root_o = root_s[SW-1];
	assign sb_o   = sb_s[SW-1];
endmodule

// ===== design/rmq_div.sv =====
// Pipelined restoring divider lane, one quotient bit per stage.
module rmq_div #(
	parameter int NW = 37,
	parameter int SW = 19
) (
	input  logic clk,
	input  logic en,
	input  logic [SW:0] d_i,
	input  logic [NW-1:0] n_i,
	output logic [NW-1:0] q_o
);
	localparam int DRW = SW + 3;

	logic [SW:0] d_s [NW];
	logic [NW-1:0] n_s [NW];
	logic [DRW-1:0] rem_s [NW];
	logic [NW-1:0] q_s [NW];

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [SW:0] d_in;
		logic [NW-1:0] n_in, q_in;
		logic [DRW-1:0] rem_in, rem_sh, dx;
		logic ge;

		if (g == 0) begin : g_first
			assign d_in   = d_i;
			assign n_in   = n_i;
			assign rem_in = '0;
			assign q_in   = '0;
		end else begin : g_next
			assign d_in   = d_s[g-1];
			assign n_in   = n_s[g-1];
			assign rem_in = rem_s[g-1];
			assign q_in   = q_s[g-1];
		end

		assign rem_sh = {rem_in[DRW-2:0], n_in[NW-1]};
		assign dx     = {2'b00, d_in};
		assign ge     = (rem_sh >= dx);

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[g]   <= d_in;
				n_s[g]   <= {n_in[NW-2:0], 1'b0};
				rem_s[g] <= ge ? (rem_sh - dx) : rem_sh;
				q_s[g]   <= {q_in[NW-2:0], ge};
			end
		end
	end

	assign q_o = q_s[NW-1];
endmodule

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
// Rotation matrix to quaternion (Shepperd's method), top level.
//
// Channel mat takes one beat per 3x3 rotation matrix: nine signed fixed-point
// entries m00..m22, row-major, FRAC_BITS fraction bits. Channel quat returns
// one beat per matrix: quat_w/x/y/z saturated to DATA_WIDTH bits, case_taken
// naming the branch and degenerate set for a non-positive radicand.
// Results leave in the order the matrices arrived.
//
// The pipeline is one front stage, SW square-root stages
// (one root bit each, SW = (RW - 1 + FRAC_BITS + 1) / 2), NW divider stages
// (one quotient bit each, NW = DATA_WIDTH + 1 + FRAC_BITS) and the output
// register.
// Throughput is one matrix per cycle while quat is taken.
//
// The whole pipeline advances on one enable: when the output register holds
// a beat the receiver has not taken, every stage holds and mat.ready drops.
// Reset clears all valid bits; the pipeline starts empty and ready.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	rmq_mat_if.sink mat,
	rmq_quat_if.source quat
);
	localparam int DW  = DATA_WIDTH;
	localparam int RW  = ((DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1) + 3;
	localparam int XW  = RW - 1 + FRAC_BITS;
	localparam int SW  = (XW + 1) / 2;
	localparam int MW  = DW + 1;
	localparam int NW  = MW + FRAC_BITS;
	localparam int SBW = 3 * MW + 3;
	localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINN = {1'b1, {(DW-1){1'b0}}};

	logic en;
	ctl_t ctl_s1, ctl_sq;
	logic [RW-2:0] rad_s1;
	logic [MW-1:0] mag_s1 [3];
	logic [2:0] neg_s1, neg_sq;
	logic [SW-1:0] root_sq;
	logic [SBW-1:0] sb_sq;
	logic [MW-1:0] mag_sq [3];
	logic [NW-1:0] q_dv [3];

	ctl_t dl_ctl_s [NW];
	logic [SW-1:0] dl_root_s [NW];
	logic [2:0] dl_neg_s [NW];

	logic out_v_q;
	logic [DW-1:0] w_q, x_q, y_q, z_q;
	case_t sel_q;
	logic degen_q;
	logic [DW-1:0] lead_v, c0, c1, c2;
	logic [DW-1:0] w_n, x_n, y_n, z_n;
	ctl_t ctl_end;

	function automatic logic [DW-1:0] sat_q(input logic neg, input logic [NW-1:0] q);
		logic [DW-1:0] res;
		if (!neg) begin
			res = (q > {{(NW-DW){1'b0}}, MAXP}) ? MAXP : q[DW-1:0];
		end else begin
			res = (q > {{(NW-DW){1'b0}}, MINN}) ? MINN : (~q[DW-1:0] + 1'b1);
		end
		return res;
	endfunction

	assign en        = !out_v_q || quat.ready;
	assign mat.ready = en;

	rmq_front #(.DW(DW), .FRAC(FRAC_BITS), .RW(RW), .MW(MW)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(mat.valid),
		.m00(mat.m00), .m01(mat.m01), .m02(mat.m02),
		.m10(mat.m10), .m11(mat.m11), .m12(mat.m12),
		.m20(mat.m20), .m21(mat.m21), .m22(mat.m22),
		.ctl_s1(ctl_s1), .rad_s1(rad_s1), .mag_s1(mag_s1), .neg_s1(neg_s1)
	);

	rmq_sqrt #(.XW(XW), .SBW(SBW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.ctl_i(ctl_s1),
		.x_i({rad_s1, {FRAC_BITS{1'b0}}}),
		.sb_i({neg_s1, mag_s1[2], mag_s1[1], mag_s1[0]}),
		.ctl_o(ctl_sq), .root_o(root_sq), .sb_o(sb_sq)
	);

	assign mag_sq[0] = sb_sq[MW-1:0];
	assign mag_sq[1] = sb_sq[2*MW-1:MW];
	assign mag_sq[2] = sb_sq[3*MW-1:2*MW];
	assign neg_sq    = sb_sq[SBW-1 -: 3];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		rmq_div #(.NW(NW), .SW(SW)) u_div (
			.clk(clk), .en(en),
			.d_i({root_sq, 1'b0}),
			.n_i({mag_sq[l], {FRAC_BITS{1'b0}}}),
			.q_o(q_dv[l])
		);
	end

	for (genvar g = 0; g < NW; g++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dl_ctl_s[g] <= '{valid: 1'b0, sel: CASE_TRACE, degen: 1'b0};
			end else if (en) begin
				dl_ctl_s[g] <= (g == 0) ? ctl_sq : dl_ctl_s[(g == 0) ? 0 : g-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dl_root_s[g] <= (g == 0) ? root_sq : dl_root_s[(g == 0) ? 0 : g-1];
				dl_neg_s[g]  <= (g == 0) ? neg_sq : dl_neg_s[(g == 0) ? 0 : g-1];
			end
		end
	end

	assign ctl_end = dl_ctl_s[NW-1];
	assign lead_v  = sat_q(1'b0, NW'(dl_root_s[NW-1] >> 1));
	assign c0      = sat_q(dl_neg_s[NW-1][0], q_dv[0]);
	assign c1      = sat_q(dl_neg_s[NW-1][1], q_dv[1]);
	assign c2      = sat_q(dl_neg_s[NW-1][2], q_dv[2]);

	always_comb begin
		case (ctl_end.sel)
			CASE_TRACE: begin
				w_n = lead_v; x_n = c0; y_n = c1; z_n = c2;
			end
			CASE_X: begin
				w_n = c0; x_n = lead_v; y_n = c1; z_n = c2;
			end
			CASE_Y: begin
				w_n = c0; x_n = c1; y_n = lead_v; z_n = c2;
			end
			default: begin
				w_n = c0; x_n = c1; y_n = c2; z_n = lead_v;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= ctl_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_q   <= ctl_end.sel;
			degen_q <= ctl_end.degen;
			w_q     <= ctl_end.degen ? '0 : w_n;
			x_q     <= ctl_end.degen ? '0 : x_n;
			y_q     <= ctl_end.degen ? '0 : y_n;
			z_q     <= ctl_end.degen ? '0 : z_n;
		end
	end

	assign quat.valid      = out_v_q;
	assign quat.quat_w     = w_q;
	assign quat.quat_x     = x_q;
	assign quat.quat_y     = y_q;
	assign quat.quat_z     = z_q;
	assign quat.case_taken = sel_q;
	assign quat.degenerate = degen_q;

`ifndef NO_ASSERTIONS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && degen_q |-> w_q == '0 && x_q == '0 && y_q == '0 && z_q == '0)
		else $error("degenerate beat with nonzero quaternion");
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> mat.ready)
		else $error("input stalled with empty output register");
	a_lead_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && sel_q == CASE_TRACE |-> !w_q[DW-1])
		else $error("negative leading component in trace branch");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !quat.ready |=> out_v_q && $stable(w_q) && $stable(sel_q))
		else $error("output beat changed under stall");
`endif
endmodule
